FILE: src/tcw_pkg.sv
package tcw_pkg;

    localparam int CMD_W   = 2;
    localparam int CHAR_W  = 8;
    localparam int INDEX_W = 11;
    localparam int CELL_W  = 16;
    localparam int COLOR_W = 4;
    localparam int ROWO_W  = 5;
    localparam int COLO_W  = 7;
    localparam int REGI_W  = 2;

    typedef logic [CMD_W-1:0]   cmd_t;
    typedef logic [CHAR_W-1:0]  char_t;
    typedef logic [CELL_W-1:0]  cell_t;
    typedef logic [COLOR_W-1:0] color_t;
    typedef logic [REGI_W-1:0]  reg_index_t;

    localparam cmd_t CMD_PUT   = 2'd0;
    localparam cmd_t CMD_CLEAR = 2'd1;
    localparam cmd_t CMD_READ  = 2'd2;

    localparam reg_index_t REG_FG_COLOR = 2'd0;
    localparam reg_index_t REG_BG_COLOR = 2'd1;

    localparam char_t  NEWLINE_CODE = 8'h0A;
    localparam char_t  BLANK_CODE   = 8'h20;
    localparam color_t FG_RESET     = 4'h7;
    localparam color_t BG_RESET     = 4'h0;

endpackage

FILE: src/tcw_ifs.sv
interface tcw_req_if import tcw_pkg::*; ();
    logic                 valid;
    logic                 ready;
    cmd_t                 command;
    char_t                char_code;
    logic [INDEX_W-1:0]   cell_index;

    modport source (output valid, command, char_code, cell_index, input ready);
    modport sink   (input valid, command, char_code, cell_index, output ready);
endinterface

interface tcw_rsp_if import tcw_pkg::*; ();
    logic                valid;
    logic                ready;
    cell_t               read_data;
    logic [ROWO_W-1:0]   row_now;
    logic [COLO_W-1:0]   col_now;
    logic                scrolled;

    modport source (output valid, read_data, row_now, col_now, scrolled, input ready);
    modport sink   (input valid, read_data, row_now, col_now, scrolled, output ready);
endinterface

interface tcw_cfg_if import tcw_pkg::*; ();
    logic        valid;
    logic        ready;
    reg_index_t  addr;
    color_t      data;

    modport source (output valid, addr, data, input ready);
    modport sink   (input valid, addr, data, output ready);
endinterface

FILE: src/text_console_writer.sv
// channel    role    word
// request    sink    command, char_code, cell_index
// response   source  read_data, row_now, col_now, scrolled
// cfg        sink    addr (0 fg_color, 1 bg_color), data
//
// A put that does not scroll answers in the cycle after the accept; a read goes
// through the memory read register, then the response register. A scrolling put
// moves the screen up a row, one cell a cycle, then blanks the bottom row.
// A clear blanks every cell, one cell a cycle, from the cycle after the accept.
// After reset the block zeroes every memory cell before taking words.
// A word is taken only when idle and the response register is empty or draining.
module text_console_writer import tcw_pkg::*; #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic         clk,
    input  logic         rst_n,
    tcw_req_if.sink      request,
    tcw_rsp_if.source    response,
    tcw_cfg_if.sink      cfg
);

    localparam int CELLS     = ROWS * COLUMNS;
    localparam int AW        = $clog2(CELLS);
    localparam int RW        = $clog2(ROWS);
    localparam int CLW       = $clog2(COLUMNS);
    localparam int LAST_BASE = (ROWS - 1) * COLUMNS;

    localparam logic [2:0] ST_INIT  = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_READ  = 3'd2;
    localparam logic [2:0] ST_COPY  = 3'd3;
    localparam logic [2:0] ST_FILL  = 3'd4;
    localparam logic [2:0] ST_CLEAR = 3'd5;

    logic [2:0]     state_reg, state_next;
    logic [AW-1:0]  ptr_reg, ptr_next;
    logic [RW-1:0]  row_reg, row_next;
    logic [CLW-1:0] col_reg, col_next;
    color_t         fg_reg, bg_reg;
    logic           copy_pend_reg, copy_pend_next;
    logic [AW-1:0]  copy_dst_reg, copy_dst_next;
    logic           rd_ok_reg, rd_ok_next;

    logic           out_valid_reg, out_valid_next;
    cell_t          out_data_reg;
    logic [RW-1:0]  out_row_reg;
    logic [CLW-1:0] out_col_reg;
    logic           out_scr_reg;

    logic           out_load;
    cell_t          load_data;
    logic           load_scr;

    cell_t          mem [CELLS];
    cell_t          rdata_reg;
    logic           we;
    logic [AW-1:0]  waddr;
    cell_t          wdata;
    logic [AW-1:0]  raddr;

    logic           accept;
    logic [AW-1:0]  cur_addr;
    logic [CLW:0]   col_inc;
    logic           last_row;
    logic           rd_ok;
    cell_t          blank;
    logic [31:0]    row_wide;
    logic [31:0]    col_wide;

    assign request.ready = (state_reg == ST_IDLE) && (!out_valid_reg || response.ready);
    assign accept        = request.valid && request.ready;
    assign cfg.ready     = 1'b1;

    assign cur_addr = AW'(row_reg) * AW'(COLUMNS) + AW'(col_reg);
    assign col_inc  = (CLW+1)'(col_reg) + (CLW+1)'(1);
    assign last_row = (row_reg == RW'(ROWS - 1));
    assign rd_ok    = 32'(request.cell_index) < 32'(CELLS);
    assign blank    = {bg_reg, fg_reg, BLANK_CODE};

    always_comb
    begin
        state_next     = state_reg;
        ptr_next       = ptr_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        copy_pend_next = 1'b0;
        copy_dst_next  = copy_dst_reg;
        rd_ok_next     = rd_ok_reg;
        out_load       = 1'b0;
        load_data      = '0;
        load_scr       = 1'b0;
        we             = 1'b0;
        waddr          = ptr_reg;
        wdata          = blank;
        raddr          = ptr_reg;

        if (copy_pend_reg)
        begin
            we    = 1'b1;
            waddr = copy_dst_reg;
            wdata = rdata_reg;
        end

        case (state_reg)
            ST_INIT:
            begin
                we    = 1'b1;
                wdata = '0;
                if (ptr_reg == AW'(CELLS - 1))
                begin
                    state_next = ST_IDLE;
                end
                ptr_next = ptr_reg + AW'(1);
            end
            ST_IDLE:
            begin
                raddr = AW'(request.cell_index);
                if (accept)
                begin
                    case (request.command)
                        CMD_PUT:
                        begin
                            if (request.char_code != NEWLINE_CODE)
                            begin
                                we    = 1'b1;
                                waddr = cur_addr;
                                wdata = {bg_reg, fg_reg, request.char_code};
                            end
                            if (request.char_code == NEWLINE_CODE ||
                                col_inc == (CLW+1)'(COLUMNS))
                            begin
                                col_next = '0;
                                if (last_row)
                                begin
                                    state_next = ST_COPY;
                                    ptr_next   = AW'(COLUMNS);
                                end
                                else
                                begin
                                    row_next = row_reg + RW'(1);
                                    out_load = 1'b1;
                                end
                            end
                            else
                            begin
                                col_next = col_inc[CLW-1:0];
                                out_load = 1'b1;
                            end
                        end
                        CMD_CLEAR:
                        begin
                            row_next   = '0;
                            col_next   = '0;
                            ptr_next   = '0;
                            state_next = ST_CLEAR;
                        end
                        CMD_READ:
                        begin
                            rd_ok_next = rd_ok;
                            state_next = ST_READ;
                        end
                        default:
                        begin
                            out_load = 1'b1;
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                out_load   = 1'b1;
                load_data  = rd_ok_reg ? rdata_reg : '0;
                state_next = ST_IDLE;
            end
            ST_COPY:
            begin
                copy_pend_next = 1'b1;
                copy_dst_next  = ptr_reg - AW'(COLUMNS);
                if (ptr_reg == AW'(CELLS - 1))
                begin
                    state_next = ST_FILL;
                    ptr_next   = AW'(LAST_BASE);
                end
                else
                begin
                    ptr_next = ptr_reg + AW'(1);
                end
            end
            ST_FILL:
            begin
                if (!copy_pend_reg)
                begin
                    we = 1'b1;
                    if (ptr_reg == AW'(CELLS - 1))
                    begin
                        state_next = ST_IDLE;
                        out_load   = 1'b1;
                        load_scr   = 1'b1;
                    end
                    ptr_next = ptr_reg + AW'(1);
                end
            end
            ST_CLEAR:
            begin
                we = 1'b1;
                if (ptr_reg == AW'(CELLS - 1))
                begin
                    state_next = ST_IDLE;
                    out_load   = 1'b1;
                end
                ptr_next = ptr_reg + AW'(1);
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid_next = out_load || (out_valid_reg && !response.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            ptr_reg       <= '0;
            row_reg       <= '0;
            col_reg       <= '0;
            fg_reg        <= FG_RESET;
            bg_reg        <= BG_RESET;
            copy_pend_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ptr_reg       <= ptr_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            copy_pend_reg <= copy_pend_next;
            out_valid_reg <= out_valid_next;
            if (cfg.valid && cfg.ready)
            begin
                if (cfg.addr == REG_FG_COLOR)
                begin
                    fg_reg <= cfg.data;
                end
                else if (cfg.addr == REG_BG_COLOR)
                begin
                    bg_reg <= cfg.data;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        copy_dst_reg <= copy_dst_next;
        rd_ok_reg    <= rd_ok_next;
        if (out_load)
        begin
            out_data_reg <= load_data;
            out_row_reg  <= row_next;
            out_col_reg  <= col_next;
            out_scr_reg  <= load_scr;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign row_wide = 32'(out_row_reg);
    assign col_wide = 32'(out_col_reg);

    assign response.valid     = out_valid_reg;
    assign response.read_data = out_data_reg;
    assign response.row_now   = row_wide[ROWO_W-1:0];
    assign response.col_now   = col_wide[COLO_W-1:0];
    assign response.scrolled  = out_scr_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (!out_valid_reg || response.ready))
        else $error("result register overwritten before drained");

    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (out_valid_reg || state_reg != ST_IDLE))
        else $error("word accepted but no result or work followed");

    assert property (@(posedge clk) disable iff (!rst_n)
        copy_pend_reg |-> (state_reg == ST_COPY || state_reg == ST_FILL))
        else $error("scroll copy write outside scroll");

    assert property (@(posedge clk) disable iff (!rst_n)
        (32'(row_reg) < 32'(ROWS)) && (32'(col_reg) < 32'(COLUMNS)))
        else $error("cursor outside screen");

endmodule

FILE: tb/tb.sv
module tb;
    import tcw_pkg::*;

    localparam int COLUMNS        = 80;
    localparam int ROWS           = 25;
    localparam int CELLS          = ROWS * COLUMNS;
    localparam int PHASE_ITEMS    = 120;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int PRINT_CAP      = 50;

    localparam cmd_t CMD_UNUSED = 2'd3;

    typedef struct packed {
        cell_t              read_data;
        logic [ROWO_W-1:0]  row_now;
        logic [COLO_W-1:0]  col_now;
        logic               scrolled;
    } console_word_t;

    typedef struct packed {
        cmd_t                cmd;
        char_t               ch;
        logic [INDEX_W-1:0]  idx;
        logic [5:0]          reps;
        logic                typed;
        console_word_t       want;
    } script_row_t;

    localparam int SCRIPT_ROWS = 20;
    localparam script_row_t SCRIPT [SCRIPT_ROWS] = '{
        '{CMD_READ,   8'h00, 11'd0,    6'd1,  1'b1, '{16'h0000, 5'd0,  7'd0, 1'b0}},
        '{CMD_READ,   8'h00, 11'd2047, 6'd1,  1'b1, '{16'h0000, 5'd0,  7'd0, 1'b0}},
        '{CMD_UNUSED, 8'hFF, 11'h7FF,  6'd1,  1'b1, '{16'h0000, 5'd0,  7'd0, 1'b0}},
        '{CMD_PUT,    8'h41, 11'd0,    6'd1,  1'b1, '{16'h0000, 5'd0,  7'd1, 1'b0}},
        '{CMD_READ,   8'h00, 11'd0,    6'd1,  1'b1, '{16'h0741, 5'd0,  7'd1, 1'b0}},
        '{CMD_PUT,    8'h00, 11'd0,    6'd1,  1'b1, '{16'h0000, 5'd0,  7'd2, 1'b0}},
        '{CMD_PUT,    8'hFF, 11'd0,    6'd1,  1'b1, '{16'h0000, 5'd0,  7'd3, 1'b0}},
        '{CMD_READ,   8'h00, 11'd2,    6'd1,  1'b1, '{16'h07FF, 5'd0,  7'd3, 1'b0}},
        '{CMD_PUT,    8'h0A, 11'd0,    6'd1,  1'b1, '{16'h0000, 5'd1,  7'd0, 1'b0}},
        '{CMD_UNUSED, 8'h0A, 11'd0,    6'd1,  1'b1, '{16'h0000, 5'd1,  7'd0, 1'b0}},
        '{CMD_CLEAR,  8'h00, 11'd0,    6'd1,  1'b1, '{16'h0000, 5'd0,  7'd0, 1'b0}},
        '{CMD_READ,   8'h00, 11'd1999, 6'd1,  1'b1, '{16'h0720, 5'd0,  7'd0, 1'b0}},
        '{CMD_READ,   8'h00, 11'd2000, 6'd1,  1'b1, '{16'h0000, 5'd0,  7'd0, 1'b0}},
        '{CMD_READ,   8'h00, 11'd2,    6'd1,  1'b1, '{16'h0720, 5'd0,  7'd0, 1'b0}},
        '{CMD_PUT,    8'h0A, 11'd0,    6'd24, 1'b0, '{16'h0000, 5'd0,  7'd0, 1'b0}},
        '{CMD_PUT,    8'h5A, 11'd0,    6'd1,  1'b0, '{16'h0000, 5'd0,  7'd0, 1'b0}},
        '{CMD_PUT,    8'h0A, 11'd0,    6'd1,  1'b1, '{16'h0000, 5'd24, 7'd0, 1'b1}},
        '{CMD_READ,   8'h00, 11'd1840, 6'd1,  1'b0, '{16'h0000, 5'd0,  7'd0, 1'b0}},
        '{CMD_READ,   8'h00, 11'd1920, 6'd1,  1'b0, '{16'h0000, 5'd0,  7'd0, 1'b0}},
        '{CMD_PUT,    8'hAA, 11'd0,    6'd1,  1'b0, '{16'h0000, 5'd0,  7'd0, 1'b0}}
    };

    localparam int PHASES = 5;
    localparam int PHASE_FG [PHASES] = '{15, 0, 0, 15, 0};
    localparam int PHASE_BG [PHASES] = '{0, 15, 0, 15, 0};
    localparam int PHASE_SRC [PHASES] = '{0, 51, 0, 7, 0};
    localparam int PHASE_SNK [PHASES] = '{0, 0, 51, 7, 0};

    logic clk;
    logic rst_n;

    tcw_req_if req_if ();
    tcw_rsp_if rsp_if ();
    tcw_cfg_if cfg_if ();

    text_console_writer #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .request  (req_if),
        .response (rsp_if),
        .cfg      (cfg_if)
    );

    cell_t         screen_model [CELLS];
    int            cur_row;
    int            cur_col;
    color_t        fg_model;
    color_t        bg_model;
    console_word_t word_q [$];

    int src_pct;
    int snk_pct;
    logic hold_start;
    int mismatches;
    int n_items;
    int n_reads;
    int n_clears;
    int n_scrolls;
    int n_cfg_writes;
    int n_words;
    int phase_items;

    initial
    begin
        clk = 1'b0;
    end

    always #4 clk = ~clk;

    function automatic cell_t colored(input char_t ch);
        colored = {bg_model, fg_model, ch};
    endfunction

    task automatic advance_line(output logic sc);
        sc = 1'b0;
        cur_col = 0;
        cur_row++;
        if (cur_row >= ROWS)
        begin
            for (int i = 0; i < (ROWS - 1) * COLUMNS; i++)
                screen_model[i] = screen_model[i + COLUMNS];
            for (int x = 0; x < COLUMNS; x++)
                screen_model[(ROWS - 1) * COLUMNS + x] = colored(BLANK_CODE);
            cur_row = ROWS - 1;
            sc = 1'b1;
        end
    endtask

    task automatic predict_console(input cmd_t cmd, input char_t ch,
                                   input logic [INDEX_W-1:0] idx,
                                   output console_word_t res);
        cell_t rd;
        logic  sc;
        rd = '0;
        sc = 1'b0;
        case (cmd)
            CMD_PUT:
            begin
                if (ch == NEWLINE_CODE)
                    advance_line(sc);
                else
                begin
                    screen_model[cur_row * COLUMNS + cur_col] = colored(ch);
                    cur_col++;
                    if (cur_col >= COLUMNS)
                        advance_line(sc);
                end
            end
            CMD_CLEAR:
            begin
                for (int i = 0; i < CELLS; i++)
                    screen_model[i] = colored(BLANK_CODE);
                cur_row = 0;
                cur_col = 0;
            end
            CMD_READ:
            begin
                if (idx < CELLS)
                    rd = screen_model[idx];
            end
            default:
            begin
            end
        endcase
        res.read_data = rd;
        res.row_now   = cur_row[ROWO_W-1:0];
        res.col_now   = cur_col[COLO_W-1:0];
        res.scrolled  = sc;
    endtask

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        if (mismatches < PRINT_CAP)
            $display("[%0t] %s: got %0h, want %0h", $realtime, what, got, want);
        mismatches++;
    endtask

    task automatic offer_word(input cmd_t cmd, input char_t ch,
                              input logic [INDEX_W-1:0] idx,
                              input logic typed, input console_word_t want);
        console_word_t pred;
        while ($urandom_range(99) < src_pct)
        begin
            req_if.valid <= 1'b0;
            @(posedge clk);
        end
        req_if.valid      <= 1'b1;
        req_if.command    <= cmd;
        req_if.char_code  <= ch;
        req_if.cell_index <= idx;
        do
            @(negedge clk);
        while (!req_if.ready);
        @(posedge clk);
        predict_console(cmd, ch, idx, pred);
        word_q.push_back(typed ? want : pred);
        if (cmd != CMD_UNUSED)
        begin
            n_items++;
            phase_items++;
        end
        if (cmd == CMD_READ)
            n_reads++;
        if (cmd == CMD_CLEAR)
            n_clears++;
        if (pred.scrolled)
            n_scrolls++;
    endtask

    task automatic write_reg(input reg_index_t addr, input color_t data);
        cfg_if.valid <= 1'b1;
        cfg_if.addr  <= addr;
        cfg_if.data  <= data;
        do
            @(negedge clk);
        while (!cfg_if.ready);
        @(posedge clk);
        if (addr == REG_FG_COLOR)
            fg_model = data;
        else
            bg_model = data;
        n_cfg_writes++;
    endtask

    task automatic settle_idle();
        req_if.valid <= 1'b0;
        @(posedge clk);
        while (word_q.size() != 0)
            @(posedge clk);
        @(posedge clk);
    endtask

    task automatic run_traffic(input int target, input logic pressure);
        int   kind;
        int   len;
        int   near;
        logic hold_done;
        logic pause_done;
        hold_done = 1'b0;
        pause_done = 1'b0;
        phase_items = 0;
        while (phase_items < target)
        begin
            if (pressure && !hold_done && phase_items >= 20)
            begin
                hold_start <= 1'b1;
                hold_done = 1'b1;
            end
            if (pressure && !pause_done && phase_items >= 90)
            begin
                settle_idle();
                pause_done = 1'b1;
            end
            kind = $urandom_range(99);
            if (kind < 70)
            begin
                len = ($urandom_range(4) == 0) ? $urandom_range(100, 60) : $urandom_range(20);
                repeat (len)
                    offer_word(CMD_PUT, char_t'($urandom_range(255)),
                               INDEX_W'($urandom_range(2047)), 1'b0, '0);
                if ($urandom_range(99) < 85)
                    offer_word(CMD_PUT, NEWLINE_CODE, INDEX_W'($urandom_range(2047)),
                               1'b0, '0);
            end
            else if (kind < 86)
            begin
                repeat ($urandom_range(4, 1))
                begin
                    near = (cur_row * COLUMNS + cur_col + CELLS - 1 - $urandom_range(3)) % CELLS;
                    if ($urandom_range(1) == 0)
                        offer_word(CMD_READ, char_t'($urandom_range(255)),
                                   INDEX_W'(near), 1'b0, '0);
                    else
                        offer_word(CMD_READ, char_t'($urandom_range(255)),
                                   INDEX_W'($urandom_range(2047)), 1'b0, '0);
                end
            end
            else if (kind < 90)
                offer_word(CMD_CLEAR, char_t'($urandom_range(255)),
                           INDEX_W'($urandom_range(2047)), 1'b0, '0);
            else
                repeat ($urandom_range(3, 1))
                    offer_word(cmd_t'($urandom_range(3)), char_t'($urandom_range(255)),
                               INDEX_W'($urandom_range(2047)), 1'b0, '0);
        end
    endtask

    initial
    begin : receiver
        int   hold_left;
        logic hold_seen;
        hold_left = 0;
        hold_seen = 1'b0;
        rsp_if.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_start && !hold_seen)
                hold_left = HOLD_CYCLES;
            hold_seen = hold_start;
            if (hold_left > 0)
            begin
                rsp_if.ready <= 1'b0;
                hold_left--;
            end
            else
                rsp_if.ready <= ($urandom_range(99) >= snk_pct);
        end
    end

    always @(negedge clk)
    begin
        console_word_t got;
        console_word_t want;
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            got.read_data = rsp_if.read_data;
            got.row_now   = rsp_if.row_now;
            got.col_now   = rsp_if.col_now;
            got.scrolled  = rsp_if.scrolled;
            n_words++;
            if (word_q.size() == 0)
                report_mismatch("word with nothing expected", got.read_data, 0);
            else
            begin
                want = word_q.pop_front();
                if (got.read_data !== want.read_data)
                    report_mismatch("read_data", got.read_data, want.read_data);
                if (got.row_now !== want.row_now)
                    report_mismatch("row_now", got.row_now, want.row_now);
                if (got.col_now !== want.col_now)
                    report_mismatch("col_now", got.col_now, want.col_now);
                if (got.scrolled !== want.scrolled)
                    report_mismatch("scrolled", got.scrolled, want.scrolled);
            end
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(negedge clk);
            if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
                (cfg_if.valid && cfg_if.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("watchdog expired after %0d quiet cycles", WATCHDOG_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        req_if.valid = 1'b0;
        req_if.command = CMD_PUT;
        req_if.char_code = '0;
        req_if.cell_index = '0;
        cfg_if.valid = 1'b0;
        cfg_if.addr = REG_FG_COLOR;
        cfg_if.data = '0;
        hold_start = 1'b0;
        src_pct = 0;
        snk_pct = 0;
        mismatches = 0;
        n_items = 0;
        n_reads = 0;
        n_clears = 0;
        n_scrolls = 0;
        n_cfg_writes = 0;
        n_words = 0;
        phase_items = 0;
        for (int i = 0; i < CELLS; i++)
            screen_model[i] = '0;
        cur_row = 0;
        cur_col = 0;
        fg_model = FG_RESET;
        bg_model = BG_RESET;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < SCRIPT_ROWS; r++)
            repeat (SCRIPT[r].reps)
                offer_word(SCRIPT[r].cmd, SCRIPT[r].ch, SCRIPT[r].idx,
                           SCRIPT[r].typed, SCRIPT[r].want);

        for (int p = 0; p < PHASES; p++)
        begin
            settle_idle();
            src_pct = 0;
            snk_pct = 0;
            write_reg(REG_FG_COLOR, (p == 2) ? color_t'($urandom_range(15)) :
                                               color_t'(PHASE_FG[p]));
            write_reg(REG_BG_COLOR, (p == 2) ? color_t'($urandom_range(15)) :
                                               color_t'(PHASE_BG[p]));
            cfg_if.valid <= 1'b0;
            src_pct = PHASE_SRC[p];
            snk_pct = PHASE_SNK[p];
            run_traffic(PHASE_ITEMS, p == PHASES - 1);
        end

        settle_idle();
        repeat (CELLS + 10) @(posedge clk);
        if (word_q.size() != 0)
            report_mismatch("words never returned", word_q.size(), 0);

        $display("ran %0d requests: %0d reads, %0d clears, %0d scrolls, %0d register writes",
                 n_items, n_reads, n_clears, n_scrolls, n_cfg_writes);
        $display("checked %0d response words across five idle patterns and a long hold",
                 n_words);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
